@@ hw/rtl/mcsr_pkg.sv @@
// mcsr_pkg: shared constants, protocol codes and structs of the memory card responder
// used by every module under hw/rtl; no dependencies
`timescale 1ns / 1ps

package mcsr_pkg;

	// card geometry
	localparam int SECTOR_BYTES = 128;
	localparam int SECTOR_COUNT = 1024;
	localparam int OFS_W        = $clog2(SECTOR_BYTES);
	localparam int SECT_W       = $clog2(SECTOR_COUNT);
	localparam int ADDR_W       = SECT_W + OFS_W;

	// active command codes
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_ID    = 2'd3;

	// write status codes
	localparam logic [1:0] WR_GOOD      = 2'd0;
	localparam logic [1:0] WR_BADSUM    = 2'd1;
	localparam logic [1:0] WR_BADSECTOR = 2'd2;

	// link bytes
	localparam logic [7:0] SEL_BYTE    = 8'h81;
	localparam logic [7:0] OP_READ     = 8'h52;
	localparam logic [7:0] OP_WRITE    = 8'h57;
	localparam logic [7:0] OP_ID       = 8'h53;
	localparam logic [7:0] ID_FIRST    = 8'h5A;
	localparam logic [7:0] ID_SECOND   = 8'h5D;
	localparam logic [7:0] ACK_FIRST   = 8'h5C;
	localparam logic [7:0] ACK_SECOND  = 8'h5D;
	localparam logic [7:0] STAT_GOOD   = 8'h47;
	localparam logic [7:0] STAT_BADSUM = 8'h4E;
	localparam logic [7:0] NO_REPLY    = 8'hFF;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;
	localparam logic [15:0] SECTOR_MASK = 16'h03FF;

	// transfer phases
	localparam logic [7:0] PH_IDLE    = 8'd0;
	localparam logic [7:0] PH_CMD     = 8'd1;
	localparam logic [7:0] PH_ID1     = 8'd2;
	localparam logic [7:0] PH_ID2     = 8'd3;
	localparam logic [7:0] PH_SEC_HI  = 8'd4;
	localparam logic [7:0] PH_SEC_LO  = 8'd5;
	localparam logic [7:0] PH_ACK1    = 8'd6;
	localparam logic [7:0] PH_ACK2    = 8'd7;
	localparam logic [7:0] PH_ECHO_HI = 8'd8;
	localparam logic [7:0] PH_ECHO_LO = 8'd9;
	localparam logic [7:0] RD_DATA_FIRST = 8'd10;
	localparam logic [7:0] RD_DATA_LAST  = 8'(10 + SECTOR_BYTES - 1);
	localparam logic [7:0] RD_SUM        = 8'(10 + SECTOR_BYTES);
	localparam logic [7:0] RD_END        = 8'(11 + SECTOR_BYTES);
	localparam logic [7:0] WR_DATA_FIRST = 8'd6;
	localparam logic [7:0] WR_DATA_LAST  = 8'(6 + SECTOR_BYTES - 1);
	localparam logic [7:0] WR_SUM        = 8'(6 + SECTOR_BYTES);
	localparam logic [7:0] WR_ACK1       = 8'(7 + SECTOR_BYTES);
	localparam logic [7:0] WR_ACK2       = 8'(8 + SECTOR_BYTES);
	localparam logic [7:0] WR_END        = 8'(9 + SECTOR_BYTES);

	// request from the protocol engine to the card store
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} store_req_t;

	// one reply word
	typedef struct packed {
		logic [7:0] reply_byte;
		logic       contents_changed;
	} reply_t;

	// sector number to store row
	function automatic logic [SECT_W-1:0] sector_index(input logic [15:0] sector);
		logic [15:0] masked;
		masked = sector & SECTOR_MASK;
		return SECT_W'(masked % SECTOR_COUNT);
	endfunction

endpackage

@@ hw/rtl/memory_card_serial_responder.sv @@
// memory_card_serial_responder: top level of the memory card byte responder
// depends on mcsr_pkg, mcsr_proto, mcsr_store, mcsr_reply_q
`timescale 1ns / 1ps

//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------
//  in       | in  | in_valid / in_stall    | host_byte[7:0]
//  out      | out | out_valid / out_stall  | reply_byte[7:0], contents_changed
//  cfg      | in  | cfg_valid / cfg_ready  | card_present
//
//  one host byte per cycle while in_stall is low; the store read for a sector
//  data byte is issued when the previous byte is taken, and each reply word
//  is registered in the reply queue before it appears on the output
//  reset clears phase and error, sets fresh, empties the reply queue; store
//  contents stay undefined until written, so there is no clearing pass
//  a two-word reply queue keeps taking bytes while one reply waits on out_stall

module memory_card_serial_responder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       card_present,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] host_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] reply_byte,
	output logic       contents_changed
);
	import mcsr_pkg::*;

	store_req_t store_req;
	reply_t     reply_n;
	reply_t     reply_out;
	logic [7:0] rd_data;
	logic       queue_full;
	logic       accept;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = queue_full;
	assign accept    = in_valid && !queue_full;

	mcsr_proto u_proto (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (card_present),
		.accept    (accept),
		.host_byte (host_byte),
		.rd_data   (rd_data),
		.store_req (store_req),
		.reply     (reply_n)
	);

	mcsr_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	mcsr_reply_q u_reply_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (reply_n),
		.full      (queue_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (reply_out)
	);

	// output word
	assign reply_byte       = reply_out.reply_byte;
	assign contents_changed = reply_out.contents_changed;

endmodule

@@ hw/rtl/mcsr_store.sv @@
// mcsr_store: card contents, one write port and one registered read port
// depends on mcsr_pkg
`timescale 1ns / 1ps

module mcsr_store (
	input  logic                    clk,
	input  mcsr_pkg::store_req_t    req,
	output logic [7:0]              rd_data
);
	import mcsr_pkg::*;

	logic [7:0] mem [SECTOR_COUNT*SECTOR_BYTES];

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

@@ hw/rtl/mcsr_proto.sv @@
// mcsr_proto: transfer phase sequencer, flags, checksum and store addressing
// depends on mcsr_pkg; drives mcsr_store and feeds the reply queue
`timescale 1ns / 1ps

module mcsr_proto (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_data,
	input  logic                  accept,
	input  logic [7:0]            host_byte,
	input  logic [7:0]            rd_data,
	output mcsr_pkg::store_req_t  store_req,
	output mcsr_pkg::reply_t      reply
);
	import mcsr_pkg::*;

	logic        card_present_q;
	logic [7:0]  phase_q, phase_n;
	logic [1:0]  cmd_q, cmd_n, cmd_eff;
	logic [15:0] sector_q, sector_n, sector_tmp;
	logic [7:0]  csum_q, csum_n;
	logic        err_q, err_n;
	logic        fresh_q, fresh_n;
	logic [1:0]  wres_q, wres_n;

	// next state and reply for the byte on the input
	always_comb begin
		cmd_eff    = (phase_q == PH_IDLE) ? CMD_NONE : cmd_q;
		cmd_n      = cmd_eff;
		phase_n    = phase_q;
		sector_n   = sector_q;
		sector_tmp = {sector_q[15:8], host_byte};
		csum_n     = csum_q;
		err_n      = err_q;
		fresh_n    = fresh_q;
		wres_n     = wres_q;
		reply      = '{reply_byte: NO_REPLY, contents_changed: 1'b0};
		store_req.wr_en   = 1'b0;
		store_req.wr_addr = {sector_index(sector_q), OFS_W'(phase_q - WR_DATA_FIRST)};
		store_req.wr_data = host_byte;

		if (!card_present_q) begin
			reply.reply_byte = NO_REPLY;
		end else if (cmd_eff == CMD_READ) begin
			if (phase_q >= RD_DATA_FIRST && phase_q <= RD_DATA_LAST) begin
				// data prefetched at the previous byte
				reply.reply_byte = rd_data;
				csum_n  = csum_q ^ rd_data;
				phase_n = phase_q + 8'd1;
			end else begin
				phase_n = phase_q + 8'd1;
				unique case (phase_q)
					PH_ID1:     reply.reply_byte = ID_FIRST;
					PH_ID2:     reply.reply_byte = ID_SECOND;
					PH_SEC_HI: begin
						sector_n = {host_byte, sector_q[7:0]};
						reply.reply_byte = ZERO_BYTE;
					end
					PH_SEC_LO: begin
						sector_n = sector_tmp & SECTOR_MASK;
						reply.reply_byte = ZERO_BYTE;
					end
					PH_ACK1:    reply.reply_byte = ACK_FIRST;
					PH_ACK2:    reply.reply_byte = ACK_SECOND;
					PH_ECHO_HI: begin
						csum_n = sector_q[15:8];
						reply.reply_byte = sector_q[15:8];
					end
					PH_ECHO_LO: begin
						csum_n = csum_q ^ sector_q[7:0];
						reply.reply_byte = sector_q[7:0];
					end
					RD_SUM:     reply.reply_byte = csum_q;
					RD_END: begin
						phase_n = PH_IDLE;
						cmd_n   = CMD_NONE;
						reply.reply_byte = STAT_GOOD;
					end
					default: begin
						phase_n = PH_IDLE;
						cmd_n   = CMD_NONE;
						reply.reply_byte = NO_REPLY;
					end
				endcase
			end
		end else if (cmd_eff == CMD_WRITE) begin
			if (phase_q >= WR_DATA_FIRST && phase_q <= WR_DATA_LAST) begin
				store_req.wr_en = 1'b1;
				csum_n  = csum_q ^ host_byte;
				phase_n = phase_q + 8'd1;
				reply.reply_byte = ZERO_BYTE;
			end else begin
				phase_n = phase_q + 8'd1;
				unique case (phase_q)
					PH_ID1:    reply.reply_byte = ID_FIRST;
					PH_ID2:    reply.reply_byte = ID_SECOND;
					PH_SEC_HI: begin
						sector_n = {host_byte, sector_q[7:0]};
						reply.reply_byte = ZERO_BYTE;
					end
					PH_SEC_LO: begin
						// checksum seed uses the sector as received
						csum_n   = sector_tmp[15:8] ^ sector_tmp[7:0];
						sector_n = sector_tmp;
						wres_n   = WR_GOOD;
						if (sector_tmp[15:10] != 6'd0) begin
							err_n    = 1'b1;
							sector_n = sector_tmp & SECTOR_MASK;
							wres_n   = WR_BADSECTOR;
						end
						reply.reply_byte = ZERO_BYTE;
					end
					WR_SUM: begin
						if (host_byte != csum_q) begin
							err_n  = 1'b1;
							wres_n = WR_BADSUM;
						end
						reply.reply_byte = ZERO_BYTE;
					end
					WR_ACK1:   reply.reply_byte = ACK_FIRST;
					WR_ACK2:   reply.reply_byte = ACK_SECOND;
					WR_END: begin
						fresh_n = 1'b0;
						phase_n = PH_IDLE;
						cmd_n   = CMD_NONE;
						reply.contents_changed = 1'b1;
						if (wres_q == WR_GOOD) begin
							reply.reply_byte = STAT_GOOD;
						end else if (wres_q == WR_BADSUM) begin
							reply.reply_byte = STAT_BADSUM;
						end else begin
							reply.reply_byte = NO_REPLY;
						end
					end
					default: begin
						phase_n = PH_IDLE;
						cmd_n   = CMD_NONE;
						reply.reply_byte = NO_REPLY;
					end
				endcase
			end
		end else if (cmd_eff == CMD_ID) begin
			cmd_n = CMD_NONE;
			reply.reply_byte = NO_REPLY;
		end else if (phase_q == PH_IDLE) begin
			if (host_byte == SEL_BYTE) begin
				phase_n = PH_CMD;
			end
			reply.reply_byte = NO_REPLY;
		end else if (phase_q == PH_CMD) begin
			phase_n = PH_ID1;
			unique case (host_byte)
				OP_READ:  cmd_n = CMD_READ;
				OP_WRITE: cmd_n = CMD_WRITE;
				OP_ID:    cmd_n = CMD_ID;
				default:  phase_n = PH_IDLE;
			endcase
			// flag byte: error in bit 2, fresh in bit 3
			reply.reply_byte = {4'd0, fresh_q, err_q, 2'd0};
			err_n = 1'b0;
		end else begin
			phase_n = PH_IDLE;
			reply.reply_byte = NO_REPLY;
		end

		// prefetch the byte the next read data phase will need
		store_req.wr_en   = store_req.wr_en & accept;
		store_req.rd_en   = accept;
		store_req.rd_addr = {sector_index(sector_n), OFS_W'(phase_n - RD_DATA_FIRST)};
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_present_q <= 1'b1;
		end else if (cfg_we) begin
			card_present_q <= cfg_data;
		end
	end

	// protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cmd_q    <= CMD_NONE;
			sector_q <= '0;
			csum_q   <= '0;
			err_q    <= 1'b0;
			fresh_q  <= 1'b1;
			wres_q   <= WR_GOOD;
		end else if (accept) begin
			phase_q  <= phase_n;
			cmd_q    <= cmd_n;
			sector_q <= sector_n;
			csum_q   <= csum_n;
			err_q    <= err_n;
			fresh_q  <= fresh_n;
			wres_q   <= wres_n;
		end
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= RD_END)
		else $error("phase beyond end of read transfer");

	a_store_write_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.wr_en |-> (cmd_eff == CMD_WRITE && card_present_q))
		else $error("store written outside a write transfer");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && reply.contents_changed) |=> (phase_q == PH_IDLE && !fresh_q))
		else $error("completed write did not end the transfer");
`endif

endmodule

@@ hw/rtl/mcsr_reply_q.sv @@
// mcsr_reply_q: two-entry reply queue between the sequencer and the output port
// depends on mcsr_pkg
`timescale 1ns / 1ps

module mcsr_reply_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mcsr_pkg::reply_t  push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output mcsr_pkg::reply_t  out_data
);
	import mcsr_pkg::*;

	reply_t     entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("reply queue count out of range");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && count_q == 2'd1) |=> full)
		else $error("reply queue not full after second word");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 2'd1))
		else $error("reply queue count did not drop on pop");
`endif

endmodule
